// ----- rtl/ppm_frame_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// PPM frame decoder assertion macros
// Shared macros for the concurrent checks of the decoder. They expect clk
// and rst to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_TOP_ASSERT_SVH
`define PPM_FRAME_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPMFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPMFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ppmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Sizes, register indexes, controller states and the command and status
// bundles shared by the decoder modules.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

  localparam int NUM_CHANNELS = 8;

  localparam int TIME_W      = 32;
  localparam int PULSE_W     = 12;
  localparam int CH_INDEX_W  = 4;
  localparam int MIN_GAP_W   = 16;
  localparam int MAX_CH_W    = 12;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NEXT_W = $clog2(NUM_CHANNELS + 1);

  localparam logic [MIN_GAP_W-1:0] MIN_GAP_RESET = MIN_GAP_W'(4000);
  localparam logic [MAX_CH_W-1:0]  MAX_CH_RESET  = MAX_CH_W'(2100);

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME_GAP = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CHANNEL   = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } ppmfd_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit_step;
  } ppmfd_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic emit_last;
  } ppmfd_status_t;

endpackage

// ----- rtl/ppmfd_if.sv -----
// ----------------------------------------------------------------------------
// PPM frame decoder channel interfaces
// Valid/ready channels for edge timestamps in and channel results out.
// ----------------------------------------------------------------------------
interface ppmfd_capture_if import ppmfd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] edge_time_us;

  modport source (output valid, output edge_time_us, input ready);
  modport sink (input valid, input edge_time_us, output ready);
endinterface

interface ppmfd_result_if import ppmfd_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CH_INDEX_W-1:0] channel_index;
  logic [PULSE_W-1:0]    pulse_us;
  logic                  frame_last;

  modport source (output valid, output channel_index, output pulse_us,
                  output frame_last, input ready);
  modport sink (input valid, input channel_index, input pulse_us,
                input frame_last, output ready);
endinterface

// ----- rtl/ppmfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// PPM frame decoder controller
// Sequences capture, evaluation and frame emission, and drives the
// handshakes of both channels.
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_top_assert.svh"

module ppmfd_ctrl import ppmfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cap_valid,
  output logic          cap_ready,
  output logic          res_valid,
  input  logic          res_ready,
  input  ppmfd_status_t status,
  output ppmfd_cmd_t    cmd
);

  ppmfd_state_t state;
  ppmfd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cap_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = status.frame_done ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (res_ready && status.emit_last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cap_ready     = 1'b0;
    res_valid     = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        cap_ready   = 1'b1;
        cmd.capture = cap_valid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_EMIT: begin
        res_valid     = 1'b1;
        cmd.emit_step = res_ready;
      end
      default: begin
        cap_ready = 1'b0;
      end
    endcase
  end

  `PPMFD_ASSERT_SAME(a_no_overlap, cap_ready, !res_valid, "input taken while emitting")
  `PPMFD_ASSERT_NEXT(a_eval_one_cycle, state == ST_EVAL, state != ST_EVAL, "evaluation stuck")
  `PPMFD_ASSERT_NEXT(a_emit_holds, res_valid && !(res_ready && status.emit_last), res_valid, "frame cut short")

endmodule

// ----- rtl/ppmfd_dp.sv -----
// ----------------------------------------------------------------------------
// PPM frame decoder datapath
// Interval measurement, sync and pulse limit checks, the channel store and
// the emission counter, plus the two configuration registers.
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_top_assert.svh"

module ppmfd_dp import ppmfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [TIME_W-1:0]      edge_time_us,
  input  ppmfd_cmd_t             cmd,
  output ppmfd_status_t          status,
  output logic [CH_INDEX_W-1:0]  channel_index,
  output logic [PULSE_W-1:0]     pulse_us,
  output logic                   frame_last
);

  logic [MIN_GAP_W-1:0] min_gap;
  logic [MAX_CH_W-1:0]  max_ch;
  logic [TIME_W-1:0]    prev_time;
  logic [TIME_W-1:0]    now_time;
  logic [NEXT_W-1:0]    next_channel;
  logic [PULSE_W-1:0]   store [NUM_CHANNELS];
  logic [SLOT_W-1:0]    emit_idx;

  logic [TIME_W-1:0] interval;
  logic              waiting;
  logic              gap_ok;
  logic              pulse_ok;
  logic              last_slot;

  assign interval  = now_time - prev_time;
  assign waiting   = (next_channel == NEXT_W'(NUM_CHANNELS));
  assign gap_ok    = (interval >= TIME_W'(min_gap));
  assign pulse_ok  = (interval <= TIME_W'(max_ch));
  assign last_slot = (next_channel == NEXT_W'(NUM_CHANNELS - 1));

  assign status.frame_done = !waiting && pulse_ok && last_slot;
  assign status.emit_last  = (emit_idx == SLOT_W'(NUM_CHANNELS - 1));

  assign channel_index = CH_INDEX_W'(emit_idx);
  assign pulse_us      = store[emit_idx];
  assign frame_last    = status.emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= MIN_GAP_RESET;
      max_ch  <= MAX_CH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_FRAME_GAP) begin
        min_gap <= cfg_data[MIN_GAP_W-1:0];
      end else if (cfg_index == CFG_MAX_CHANNEL) begin
        max_ch <= cfg_data[MAX_CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_time <= edge_time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && cmd.eval && !waiting && pulse_ok) begin
      store[next_channel[SLOT_W-1:0]] <= interval[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time    <= '0;
      next_channel <= NEXT_W'(NUM_CHANNELS);
      emit_idx     <= '0;
    end else begin
      if (cmd.eval) begin
        prev_time <= now_time;
        emit_idx  <= '0;
        if (waiting) begin
          next_channel <= gap_ok ? '0 : NEXT_W'(NUM_CHANNELS);
        end else if (!pulse_ok) begin
          next_channel <= NEXT_W'(NUM_CHANNELS);
        end else begin
          next_channel <= next_channel + NEXT_W'(1);
        end
      end else if (cmd.emit_step) begin
        emit_idx <= status.emit_last ? '0 : emit_idx + SLOT_W'(1);
      end
    end
  end

  `PPMFD_ASSERT_SAME(a_next_range, 1'b1, next_channel <= NEXT_W'(NUM_CHANNELS), "slot pointer out of range")
  `PPMFD_ASSERT_NEXT(a_emit_wrap, cmd.emit_step && status.emit_last, emit_idx == '0, "emit counter did not wrap")
  `PPMFD_ASSERT_NEXT(a_done_waits, cmd.eval && status.frame_done, waiting, "frame end did not rearm sync")

endmodule

// ----- rtl/ppm_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// PPM frame decoder top level
// Decodes RC receiver PPM frames from rising-edge timestamps and emits one
// result per channel when a frame completes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                  Transfer when
//  capture   in   edge_time_us[31:0]                       valid && ready
//  result    out  channel_index[3:0] pulse_us[11:0] last   valid && ready
//  cfg       in   cfg_index, cfg_data (write only)         cfg_we
//
// An edge is captured in the idle state, then its interval is measured and
// classified in the evaluation state. A completing edge emits NUM_CHANNELS
// results, one per cycle while result.ready is high, from the channel store.
// No edge is accepted while a frame is being emitted. Reset is synchronous
// and puts the decoder in the wait-for-sync state with no clearing pass.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_top import ppmfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ppmfd_capture_if.sink          capture,
  ppmfd_result_if.source         result
);

  ppmfd_cmd_t    cmd;
  ppmfd_status_t status;

  ppmfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cap_valid (capture.valid),
    .cap_ready (capture.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ppmfd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .edge_time_us  (capture.edge_time_us),
    .cmd           (cmd),
    .status        (status),
    .channel_index (result.channel_index),
    .pulse_us      (result.pulse_us),
    .frame_last    (result.frame_last)
  );

endmodule

// ----- dv/ppm_frame_checker.sv -----
// ----------------------------------------------------------------------------
// PPM frame decoder result checker
// Watches the capture, result and register write ports of the decoder. It
// keeps its own copy of the decoder state, works out the channel values of
// every completed frame, and compares each result transfer with the oldest
// value still owed.
// ----------------------------------------------------------------------------
module ppm_frame_checker import ppmfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ppmfd_capture_if               capture,
  ppmfd_result_if                result,
  output int                     fail_count,
  output int                     pending_values
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_INDEX_W-1:0] channel_index;
    logic [PULSE_W-1:0]    pulse_us;
    logic                  frame_last;
  } channel_value_t;

  channel_value_t       frame_values_q[$];
  channel_value_t       got;
  channel_value_t       want;
  logic [TIME_W-1:0]    last_edge;
  int unsigned          slot;
  logic [PULSE_W-1:0]   pulse_store [NUM_CHANNELS];
  logic [MIN_GAP_W-1:0] min_gap;
  logic [MAX_CH_W-1:0]  max_pulse;
  int                   mismatches = 0;

  assign fail_count = mismatches;

  // A slot value of NUM_CHANNELS means the decoder is hunting for the sync gap.
  function automatic void decode_edge(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] span;
    channel_value_t    value;
    int unsigned       i;
    span = stamp - last_edge;
    last_edge = stamp;
    if (slot >= NUM_CHANNELS) begin
      slot = (span >= TIME_W'(min_gap)) ? 0 : NUM_CHANNELS;
    end else if (span > TIME_W'(max_pulse)) begin
      slot = NUM_CHANNELS;
    end else begin
      pulse_store[slot] = span[PULSE_W-1:0];
      slot++;
      if (slot == NUM_CHANNELS) begin
        for (i = 0; i < NUM_CHANNELS; i++) begin
          value.channel_index = CH_INDEX_W'(i);
          value.pulse_us      = pulse_store[i];
          value.frame_last    = (i == NUM_CHANNELS - 1);
          frame_values_q.push_back(value);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      last_edge = '0;
      slot      = NUM_CHANNELS;
      min_gap   = MIN_GAP_RESET;
      max_pulse = MAX_CH_RESET;
      frame_values_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        got.channel_index = result.channel_index;
        got.pulse_us      = result.pulse_us;
        got.frame_last    = result.frame_last;
        if (frame_values_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: unexpected result transfer: ch=%0d pulse=%0d last=%0b",
                     got.channel_index, got.pulse_us, got.frame_last);
          end
        end else begin
          want = frame_values_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result mismatch: expected ch=%0d pulse=%0d last=%0b, got ch=%0d pulse=%0d last=%0b",
                       want.channel_index, want.pulse_us, want.frame_last,
                       got.channel_index, got.pulse_us, got.frame_last);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_FRAME_GAP) begin
          min_gap = cfg_data[MIN_GAP_W-1:0];
        end else if (cfg_index == CFG_MAX_CHANNEL) begin
          max_pulse = cfg_data[MAX_CH_W-1:0];
        end
      end
      if (capture.valid && capture.ready) begin
        decode_edge(capture.edge_time_us);
      end
    end
    pending_values <= frame_values_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// PPM frame decoder testbench top
// Drives edge timestamps into the decoder as bursts with random gaps, stalls
// the result port on a changing pattern, and steps through several register
// settings between phases. A short directed sequence covers the sync
// thresholds, a resync and a counter wrap; random frames with occasional
// glitches follow. The checker beside the decoder reports the failures.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppmfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_SETTLE    = 4;
  localparam int END_DRAIN      = 20;
  localparam int PHASE_EDGES    = 35;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending_values;

  ppmfd_capture_if capture();
  ppmfd_result_if  result();

  logic [TIME_W-1:0]    stamp_us;
  logic [MIN_GAP_W-1:0] gap_setting;
  logic [MAX_CH_W-1:0]  pulse_limit;
  int                   burst_left   = 0;
  int                   edges_sent   = 0;
  int                   quiet_cycles = 0;
  sink_mode_t           sink_mode    = SINK_OPEN;
  int                   sink_phase   = 0;

  ppm_frame_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .capture   (capture),
    .result    (result)
  );

  ppm_frame_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .capture        (capture),
    .result         (result),
    .fail_count     (fail_count),
    .pending_values (pending_values)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  always @(posedge clk) begin
    if (sink_phase == 0) begin
      sink_mode  <= sink_mode_t'($urandom_range(0, 3));
      sink_phase <= $urandom_range(16, 96);
    end else begin
      sink_phase <= sink_phase - 1;
    end
    case (sink_mode)
      SINK_OPEN: begin
        result.ready <= 1'b1;
      end
      SINK_RANDOM: begin
        result.ready <= 1'($urandom_range(0, 1));
      end
      SINK_SPARSE: begin
        result.ready <= ($urandom_range(0, 4) == 0);
      end
      default: begin
        result.ready <= (sink_phase % 4 == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (capture.valid && capture.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_edge(input logic [TIME_W-1:0] stamp);
    if (burst_left == 0) begin
      capture.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    stamp_us = stamp;
    edges_sent++;
    capture.valid        <= 1'b1;
    capture.edge_time_us <= stamp;
    do @(posedge clk); while (!capture.ready);
  endtask

  task automatic send_after(input logic [TIME_W-1:0] span);
    send_edge(stamp_us + span);
  endtask

  task automatic wait_idle();
    capture.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_values != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [MIN_GAP_W-1:0] gap,
                            input logic [MAX_CH_W-1:0] limit);
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    write_reg(CFG_MIN_FRAME_GAP, CFG_DATA_W'(gap));
    word = CFG_DATA_W'($urandom());
    word[MAX_CH_W-1:0] = limit;
    write_reg(CFG_MAX_CHANNEL, word);
    write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom()));
    gap_setting = gap;
    pulse_limit = limit;
  endtask

  // One sync gap followed by a full set of channel pulses, with occasional glitches.
  task automatic send_frame_burst();
    logic [TIME_W-1:0] span;
    int unsigned       k;
    case ($urandom_range(0, 9))
      0: span = TIME_W'(gap_setting);
      1: span = (gap_setting == 0) ? '0 : TIME_W'(gap_setting) - 1;
      2: span = $urandom();
      default: span = TIME_W'(gap_setting) + $urandom_range(0, 6000);
    endcase
    send_after(span);
    for (k = 0; k < NUM_CHANNELS; k++) begin
      case ($urandom_range(0, 39))
        0: span = TIME_W'(pulse_limit) + 1 + $urandom_range(0, 3000);
        1: span = TIME_W'(pulse_limit);
        2: span = '0;
        3: span = $urandom();
        default: span = $urandom_range(0, pulse_limit);
      endcase
      send_after(span);
    end
  endtask

  task automatic run_phase(input logic [MIN_GAP_W-1:0] gap,
                           input logic [MAX_CH_W-1:0] limit);
    int phase_start;
    set_config(gap, limit);
    phase_start = edges_sent;
    while (edges_sent - phase_start < PHASE_EDGES) begin
      send_frame_burst();
      if ($urandom_range(0, 9) == 0) begin
        wait_idle();
      end
    end
  endtask

  initial begin
    int unsigned opening [NUM_CHANNELS];
    opening              = '{2100, 0, 1, 1500, 2099, 1000, 700, 2100};
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_MIN_FRAME_GAP;
    cfg_data             = '0;
    capture.valid        = 1'b0;
    capture.edge_time_us = '0;
    result.ready         = 1'b0;
    stamp_us             = '0;
    gap_setting          = MIN_GAP_RESET;
    pulse_limit          = MAX_CH_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The first edge is measured from zero and lands exactly on the sync threshold.
    send_after(TIME_W'(MIN_GAP_RESET));
    foreach (opening[i]) begin
      send_after(opening[i]);
    end
    send_after(TIME_W'(MIN_GAP_RESET) - 1);
    send_after(TIME_W'(MIN_GAP_RESET));
    send_after(1200);
    send_after(TIME_W'(MAX_CH_RESET) + 1);
    // A frame that straddles the counter wrap.
    send_edge(32'hFFFF_F800);
    repeat (NUM_CHANNELS) send_after(600);

    run_phase(MIN_GAP_RESET, MAX_CH_RESET);
    run_phase('1, '1);
    run_phase('0, '0);
    run_phase(MIN_GAP_W'(1), '1);
    run_phase(MIN_GAP_W'($urandom_range(0, 8000)), MAX_CH_W'($urandom_range(0, 4095)));
    run_phase('0, '1);
    run_phase('1, '0);
    run_phase(MIN_GAP_W'($urandom_range(0, 8000)), MAX_CH_W'($urandom_range(0, 4095)));

    wait_idle();
    repeat (END_DRAIN) @(posedge clk);
    if (pending_values != 0) begin
      $display("ERROR: %0d channel results never arrived", pending_values);
    end
    if (fail_count == 0 && pending_values == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ppmfd_pkg.sv
rtl/ppmfd_if.sv
rtl/ppmfd_ctrl.sv
rtl/ppmfd_dp.sv
rtl/ppm_frame_decoder_top.sv
dv/ppm_frame_checker.sv
dv/tb_top.sv
